// ===== src/hdt_pkg.sv =====
// Shared types, constants and functions for the HOTP digest truncation block.
// Used by the top, the remainder unit and both checkers; depends on nothing.
package hdt_pkg;

  localparam int DIGEST_BYTES = 20;
  localparam int ADDR_W       = $clog2(DIGEST_BYTES);
  localparam int CODE_W       = 31;
  localparam int OTP_W        = 30;
  localparam int DIGIT_W      = 4;
  localparam int RECIP_W      = 32;
  localparam int PROD_W       = CODE_W + RECIP_W;
  localparam int BACK_W       = CODE_W + OTP_W;

  localparam logic [DIGIT_W-1:0] DIGIT_RESET = DIGIT_W'(6);
  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(DIGEST_BYTES - 1);
  localparam logic [3:0]         OFFSET_MASK = 4'hF;

  typedef struct packed {
    logic               start;
    logic [CODE_W-1:0]  code;
    logic [DIGIT_W-1:0] digits;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [OTP_W-1:0] result;
  } mod_rsp_t;

  // Ten to the power of the digit count, with the count saturated to 1..9.
  function automatic logic [OTP_W-1:0] pow_ten(input logic [DIGIT_W-1:0] d);
    logic [OTP_W-1:0] p;
    case (d)
      4'd0, 4'd1: p = OTP_W'(10);
      4'd2:       p = OTP_W'(100);
      4'd3:       p = OTP_W'(1000);
      4'd4:       p = OTP_W'(10000);
      4'd5:       p = OTP_W'(100000);
      4'd6:       p = OTP_W'(1000000);
      4'd7:       p = OTP_W'(10000000);
      4'd8:       p = OTP_W'(100000000);
      default:    p = OTP_W'(1000000000);
    endcase
    return p;
  endfunction

  // Two to the 32nd divided by the matching power of ten, rounded down.
  function automatic logic [RECIP_W-1:0] recip_ten(input logic [DIGIT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd0, 4'd1: r = RECIP_W'(429496729);
      4'd2:       r = RECIP_W'(42949672);
      4'd3:       r = RECIP_W'(4294967);
      4'd4:       r = RECIP_W'(429496);
      4'd5:       r = RECIP_W'(42949);
      4'd6:       r = RECIP_W'(4294);
      4'd7:       r = RECIP_W'(429);
      4'd8:       r = RECIP_W'(42);
      default:    r = RECIP_W'(4);
    endcase
    return r;
  endfunction

endpackage

// ===== src/hotp_digest_truncation.sv =====
// Top level of the HOTP dynamic truncation block: byte sequencer around the
// digest RAM and the remainder unit. Depends on hdt_pkg, hdt_ram, hdt_mod_unit.
//
// Usage:
//   Input channel (in_valid / in_stall / digest_byte) takes one digest byte
//   per word, first byte first. Bytes are taken one per cycle and written to
//   the digest RAM. The last byte gives the offset (its low nibble); in_stall
//   then rises while four bytes are read from the RAM, one read per cycle
//   through its single read port, while the remainder unit works and until
//   the result is loaded into the output register. When that register is
//   free, a digest passes through loading, the reads from the RAM, the
//   capture of the last read byte, the remainder unit start, its work and
//   the output load.
//   Output channel (out_valid / out_stall / otp_value / truncated_code)
//   gives one word per digest from an output register. While the receiver
//   stalls, the word holds and the next digest is still collected; its
//   result waits in the remainder unit until the output register is free.
//   cfg_write / cfg_data set the digit count (1..9, saturated); write it
//   only while no digest is in progress. Reset (rst, synchronous) drops any
//   partial digest and any pending word and sets the digit count to six.
module hotp_digest_truncation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [hdt_pkg::DIGIT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   digest_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hdt_pkg::OTP_W-1:0]    otp_value,
  output logic [hdt_pkg::CODE_W-1:0]   truncated_code
);
  import hdt_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_READ,
    S_DRAIN,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  state_t            state;
  logic [DIGIT_W-1:0] digit_count;
  logic [ADDR_W-1:0] byte_count;
  logic [3:0]        offset;
  logic [1:0]        rd_idx;
  logic              rd_valid;
  logic [CODE_W-1:0] code;

  logic              accept;
  logic              out_load;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  mod_req_t          mreq;
  mod_rsp_t          mrsp;

  assign in_stall = (state != S_COLLECT);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign ram_re   = (state == S_READ);
  assign ram_raddr = ADDR_W'(offset) + ADDR_W'(rd_idx);

  assign mreq.start  = (state == S_START);
  assign mreq.code   = code;
  assign mreq.digits = digit_count;

  hdt_ram #(
    .DEPTH (DIGEST_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (byte_count),
    .wdata (digest_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hdt_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= DIGIT_RESET;
    end else if (cfg_write) begin
      digit_count <= cfg_data;
    end
  end

  // Bytes arrive in the cycle after their read; the top bit of the first byte
  // falls off the 31-bit register.
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      code <= {code[CODE_W-9:0], ram_rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      byte_count <= '0;
      rd_idx     <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= ram_re;
      if (out_load) begin
        out_valid      <= 1'b1;
        otp_value      <= mrsp.result;
        truncated_code <= code;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_COLLECT: begin
          if (accept) begin
            if (byte_count == LAST_ADDR) begin
              byte_count <= '0;
              offset     <= digest_byte[3:0] & OFFSET_MASK;
              rd_idx     <= '0;
              state      <= S_READ;
            end else begin
              byte_count <= byte_count + ADDR_W'(1);
            end
          end
        end
        S_READ: begin
          rd_idx <= rd_idx + 2'd1;
          if (rd_idx == 2'd3) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mrsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_COLLECT;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

endmodule

// ===== src/hdt_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and valid in the cycle after the read address; no dependencies.
module hdt_ram #(
  parameter int DEPTH = 20,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/hdt_mod_unit.sv =====
// Remainder unit: code modulo a power of ten by reciprocal multiplication.
// A request steps through the scale, back, subtract and fix states; a new start is taken only in idle. Uses hdt_pkg.
module hdt_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  hdt_pkg::mod_req_t req,
  output hdt_pkg::mod_rsp_t rsp
);
  import hdt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SCALE,
    M_BACK,
    M_SUB,
    M_FIX
  } mstate_t;

  mstate_t           state;
  logic              done;
  logic [CODE_W-1:0] code;
  logic [OTP_W-1:0]  divisor;
  logic [RECIP_W-1:0] recip;
  logic [CODE_W-1:0] quot;
  logic [CODE_W-1:0] back;
  logic [CODE_W-1:0] rem_est;
  logic [OTP_W-1:0]  result;
  logic [PROD_W-1:0] scaled;
  logic [BACK_W-1:0] product;

  // The reciprocal is rounded down, so the quotient estimate is never high and
  // at most one low; a single compare and subtract finishes the remainder.
  assign scaled  = PROD_W'(code) * PROD_W'(recip);
  assign product = BACK_W'(quot) * BACK_W'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == M_FIX);
      case (state)
        M_IDLE: begin
          if (req.start) begin
            code    <= req.code;
            divisor <= pow_ten(req.digits);
            recip   <= recip_ten(req.digits);
            state   <= M_SCALE;
          end
        end
        M_SCALE: begin
          quot  <= scaled[PROD_W-1:RECIP_W];
          state <= M_BACK;
        end
        M_BACK: begin
          back  <= product[CODE_W-1:0];
          state <= M_SUB;
        end
        M_SUB: begin
          rem_est <= code - back;
          state   <= M_FIX;
        end
        M_FIX: begin
          if (rem_est >= CODE_W'(divisor)) begin
            result <= OTP_W'(rem_est - CODE_W'(divisor));
          end else begin
            result <= rem_est[OTP_W-1:0];
          end
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ===== src/hdt_checker.sv =====
// Port-level checker for hotp_digest_truncation, attached with a bind.
// Depends on hdt_pkg for field widths.
module hdt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [hdt_pkg::OTP_W-1:0]   otp_value,
  input logic [hdt_pkg::CODE_W-1:0]  truncated_code
);
  import hdt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(otp_value) && $stable(truncated_code))
    else $error("output word changed while stalled");

  a_otp_le_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, otp_value} <= truncated_code))
    else $error("remainder exceeds the truncated code");

  a_otp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (otp_value < OTP_W'(1000000000)))
    else $error("remainder not below the largest power of ten");

endmodule

bind hotp_digest_truncation hdt_checker u_hdt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .otp_value      (otp_value),
  .truncated_code (truncated_code)
);

// ===== tb/hotp_truncation_checker.sv =====
`timescale 1ns / 100ps
// Checker for the HOTP digest truncation block: watches both channels and the
// digit-count port, predicts each output word and compares it. Uses hdt_pkg.
module hotp_truncation_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [hdt_pkg::DIGIT_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  digest_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [hdt_pkg::OTP_W-1:0]   otp_value,
  input  logic [hdt_pkg::CODE_W-1:0]  truncated_code,
  output int                          fail_count,
  output int                          pending
);

  import hdt_pkg::*;

  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic [OTP_W-1:0]  otp;
    logic [CODE_W-1:0] code;
  } otp_word_t;

  logic [7:0]         digest_bytes [DIGEST_BYTES];
  int                 bytes_seen;
  logic [DIGIT_W-1:0] digits;
  otp_word_t          expected_codes [EXP_DEPTH];
  int                 wr_count;
  int                 rd_count;

  // Dynamic truncation of the collected digest, then the remainder by ten to
  // the digit count, with the count saturated to 1..9.
  function automatic otp_word_t truncate_digest(input logic [DIGIT_W-1:0] d);
    otp_word_t   w;
    int          off;
    int          n;
    logic [31:0] modulus;
    off = int'(digest_bytes[DIGEST_BYTES-1][3:0]);
    w.code = {digest_bytes[off][6:0], digest_bytes[off+1], digest_bytes[off+2],
              digest_bytes[off+3]};
    n = (d < 1) ? 1 : ((d > 9) ? 9 : int'(d));
    modulus = 32'd1;
    repeat (n) modulus = modulus * 32'd10;
    w.otp = OTP_W'({1'b0, w.code} % modulus);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    otp_word_t w;
    if (rst) begin
      bytes_seen = 0;
      digits     = DIGIT_RESET;
    end else begin
      if (cfg_write) digits = cfg_data;
      if (in_valid && !in_stall) begin
        digest_bytes[bytes_seen] = digest_byte;
        bytes_seen++;
        if (bytes_seen == DIGEST_BYTES) begin
          bytes_seen = 0;
          expected_codes[wr_count % EXP_DEPTH] = truncate_digest(digits);
          wr_count++;
        end
      end
      if (out_valid && !out_stall) begin
        if (wr_count == rd_count) begin
          report_mismatch("unexpected word (truncated_code)", 32'(truncated_code), 32'd0);
        end else begin
          w = expected_codes[rd_count % EXP_DEPTH];
          rd_count++;
          if (otp_value !== w.otp)
            report_mismatch("otp_value", 32'(otp_value), 32'(w.otp));
          if (truncated_code !== w.code)
            report_mismatch("truncated_code", 32'(truncated_code), 32'(w.code));
        end
      end
    end
    pending = wr_count - rd_count;
  end

endmodule

// ===== tb/hotp_digest_truncation_test.sv =====
`timescale 1ns / 100ps
// Top of the HOTP digest truncation testbench: clock, reset, digest and
// digit-count stimulus, receiver stalls and the verdict. Uses the checker.
module hotp_digest_truncation_test;

  import hdt_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_DIGESTS  = 6;
  localparam int RANDOM_PHASES  = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [DIGIT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          digest_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OTP_W-1:0]    otp_value;
  logic [CODE_W-1:0]   truncated_code;

  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  int                  idle_pct = 6;
  int                  stall_pct = 45;
  logic                hold_request = 1'b0;
  logic [7:0]          digest_buf [DIGEST_BYTES];

  // Digit settings for the random phases, saturating values among them.
  logic [DIGIT_W-1:0]  phase_digits [RANDOM_PHASES] =
    '{4'd1, 4'd9, 4'd0, 4'd15, 4'd3, 4'd10, 4'd7, 4'd6};

  hotp_digest_truncation i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .digest_byte    (digest_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .otp_value      (otp_value),
    .truncated_code (truncated_code)
  );

  hotp_truncation_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .digest_byte    (digest_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .otp_value      (otp_value),
    .truncated_code (truncated_code),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    digest_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_digest();
    for (int i = 0; i < DIGEST_BYTES; i++) send_byte(digest_buf[i]);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random digest; the offset nibble sweeps all values on even digests, and
  // some windows are forced to all ones or mostly zeros.
  task automatic fill_random(input int idx);
    int off;
    int shape;
    for (int i = 0; i < DIGEST_BYTES; i++) digest_buf[i] = 8'($urandom_range(255));
    off = (idx % 2 == 1) ? $urandom_range(15) : (idx / 2) % 16;
    digest_buf[DIGEST_BYTES-1][3:0] = 4'(off);
    shape = $urandom_range(3);
    if (shape == 1) begin
      for (int i = 0; i < 4; i++) digest_buf[off+i] = 8'hFF;
    end else if (shape == 2) begin
      for (int i = 0; i < 3; i++) digest_buf[off+i] = 8'h00;
    end
  endtask

  task automatic write_digits(input logic [DIGIT_W-1:0] v);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: all ones (offset 15, top bit masked) and all zeros (offset 0).
    for (int i = 0; i < DIGEST_BYTES; i++) digest_buf[i] = 8'hFF;
    send_digest();
    for (int i = 0; i < DIGEST_BYTES; i++) digest_buf[i] = 8'h00;
    send_digest();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_digits(phase_digits[p]);
      if (p < 3) begin
        idle_pct  = 6;
        stall_pct = 45;
      end else if (p < 6) begin
        idle_pct  = 45;
        stall_pct = 6;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (p == 1) hold_request <= 1'b1;
      for (int d = 0; d < PHASE_DIGESTS; d++) begin
        fill_random(p * PHASE_DIGESTS + d);
        send_digest();
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== hotp_digest_truncation.f =====
src/hdt_pkg.sv
src/hdt_ram.sv
src/hdt_mod_unit.sv
src/hotp_digest_truncation.sv
src/hdt_checker.sv
tb/hotp_truncation_checker.sv
tb/hotp_digest_truncation_test.sv
